// ===== rtl/rwst_pkg.sv =====
// Shared constants, operation and status codes, and storage control type for the slot table.
package rwst_pkg;

  localparam int FUNC_W   = 3;
  localparam int SEQ_W    = 32;
  localparam int PAY_W    = 64;
  localparam int STATUS_W = 2;
  localparam int CNT_W    = 7;
  localparam int CFG_W    = 7;

  localparam logic [FUNC_W-1:0] FUNC_ADD    = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_REMOVE = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_ACK    = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_LOOKUP = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 3'd4;

  localparam logic [STATUS_W-1:0] STAT_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_FULL      = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 2'd2;

  localparam logic [CFG_W-1:0] ACTIVE_RESET = 7'd8;

  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } mem_ctl_t;

endpackage

// ===== rtl/rwst_slot_store.sv =====
// Sequence and descriptor storage for the slots, one write and one registered read per cycle.
module rwst_slot_store #(
  parameter int SLOTS = 8
) (
  input  logic                          clk,
  input  rwst_pkg::mem_ctl_t            ctl,
  input  logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0] wr_addr,
  input  logic [rwst_pkg::SEQ_W-1:0]    wr_seq,
  input  logic [rwst_pkg::PAY_W-1:0]    wr_payload,
  input  logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0] rd_addr,
  output logic [rwst_pkg::SEQ_W-1:0]    rd_seq,
  output logic [rwst_pkg::PAY_W-1:0]    rd_payload
);

  logic [rwst_pkg::SEQ_W-1:0] seq_mem [SLOTS];
  logic [rwst_pkg::PAY_W-1:0] pay_mem [SLOTS];
  logic [rwst_pkg::SEQ_W-1:0] rd_seq_r;
  logic [rwst_pkg::PAY_W-1:0] rd_payload_r;

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      seq_mem[wr_addr] <= wr_seq;
      pay_mem[wr_addr] <= wr_payload;
    end
    if (ctl.rd_en) begin
      rd_seq_r     <= seq_mem[rd_addr];
      rd_payload_r <= pay_mem[rd_addr];
    end
  end

  assign rd_seq     = rd_seq_r;
  assign rd_payload = rd_payload_r;

endmodule

// ===== rtl/retransmit_window_slot_table.sv =====
// Retransmission window slot table: add, remove, cumulative ack, lookup and clear over slots.
//
//   port group   direction  handshake              contents
//   in_*         input      in_valid / in_stall    func, seq_key, entry_payload
//   out_*        output     out_valid / out_stall  status, found, seq, payload, count, full
//   cfg_*        input      cfg_valid / cfg_ready  active slot count
//
// One item at a time. A scan reads one slot per cycle through the shared compare
// and the single storage read port, each compare following its read; add stops at
// the first free slot, remove and lookup at the first hit, ack scans every active
// slot, and clear or an unused code ends at once. in_stall is high from accept until
// the result is in the output register, which holds it while out_stall is high.
// Reset frees all slots at once and sets the active count to 8.
module retransmit_window_slot_table #(
  parameter int SLOTS = 8
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [rwst_pkg::CFG_W-1:0]      cfg_active_slots,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [rwst_pkg::FUNC_W-1:0]     in_func,
  input  logic [rwst_pkg::SEQ_W-1:0]      in_seq_key,
  input  logic [rwst_pkg::PAY_W-1:0]      in_entry_payload,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [rwst_pkg::STATUS_W-1:0]   out_status,
  output logic                            out_found,
  output logic [rwst_pkg::SEQ_W-1:0]      out_seq,
  output logic [rwst_pkg::PAY_W-1:0]      out_payload,
  output logic [rwst_pkg::CNT_W-1:0]      out_removed_count,
  output logic                            out_window_full
);

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = $clog2(SLOTS + 1);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_FIN  = 3'b100
  } state_t;

  state_t                          state_r, state_nxt;
  logic [rwst_pkg::CFG_W-1:0]      active_r;
  logic [SLOTS-1:0]                occ_r, occ_nxt;
  logic [CW-1:0]                   rd_cnt_r, rd_cnt_nxt;
  logic                            cmp_vld_r, cmp_vld_nxt;
  logic [IW-1:0]                   cmp_idx_r, cmp_idx_nxt;

  logic [rwst_pkg::FUNC_W-1:0]     func_r;
  logic [rwst_pkg::SEQ_W-1:0]      key_r;
  logic [rwst_pkg::PAY_W-1:0]      pay_r;

  logic [rwst_pkg::STATUS_W-1:0]   res_status_r, res_status_nxt;
  logic                            res_found_r, res_found_nxt;
  logic [rwst_pkg::SEQ_W-1:0]      res_seq_r, res_seq_nxt;
  logic [rwst_pkg::PAY_W-1:0]      res_pay_r, res_pay_nxt;
  logic [rwst_pkg::CNT_W-1:0]      res_cnt_r, res_cnt_nxt;

  logic                            out_valid_r;
  logic [rwst_pkg::STATUS_W-1:0]   out_status_r;
  logic                            out_found_r;
  logic [rwst_pkg::SEQ_W-1:0]      out_seq_r;
  logic [rwst_pkg::PAY_W-1:0]      out_pay_r;
  logic [rwst_pkg::CNT_W-1:0]      out_cnt_r;
  logic                            out_full_r;

  logic                            in_accept;
  logic                            out_load;
  logic [CW-1:0]                   live_n;
  logic [SLOTS-1:0]                act_mask;
  logic                            full_now;
  logic                            slot_busy;
  logic                            key_eq;
  logic                            key_le;
  logic                            scan_end;
  logic                            done;

  rwst_pkg::mem_ctl_t              mem_ctl;
  logic [rwst_pkg::SEQ_W-1:0]      rd_seq;
  logic [rwst_pkg::PAY_W-1:0]      rd_payload;

  rwst_slot_store #(
    .SLOTS(SLOTS)
  ) u_store (
    .clk        (clk),
    .ctl        (mem_ctl),
    .wr_addr    (cmp_idx_r),
    .wr_seq     (key_r),
    .wr_payload (pay_r),
    .rd_addr    (rd_cnt_r[IW-1:0]),
    .rd_seq     (rd_seq),
    .rd_payload (rd_payload)
  );

  assign cfg_ready = 1'b1;
  assign in_stall  = (state_r != S_IDLE);
  assign in_accept = in_valid && (state_r == S_IDLE);

  // Out-of-range counts are clamped; the register keeps the bits written.
  always_comb begin
    if (active_r == '0) begin
      live_n = CW'(1);
    end else if (active_r > rwst_pkg::CFG_W'(SLOTS)) begin
      live_n = CW'(SLOTS);
    end else begin
      live_n = active_r[CW-1:0];
    end
  end

  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      act_mask[i] = (CW'(i) < live_n);
    end
  end

  assign full_now  = &(occ_r | ~act_mask);
  assign slot_busy = occ_r[cmp_idx_r];
  assign key_eq    = (rd_seq == key_r);
  assign key_le    = (rd_seq <= key_r);
  // Every active slot has been read and compared without the scan stopping early.
  assign scan_end  = !cmp_vld_r && (rd_cnt_r == live_n);

  always_comb begin
    state_nxt      = state_r;
    occ_nxt        = occ_r;
    rd_cnt_nxt     = rd_cnt_r;
    cmp_vld_nxt    = cmp_vld_r;
    cmp_idx_nxt    = cmp_idx_r;
    res_status_nxt = res_status_r;
    res_found_nxt  = res_found_r;
    res_seq_nxt    = res_seq_r;
    res_pay_nxt    = res_pay_r;
    res_cnt_nxt    = res_cnt_r;
    mem_ctl        = '0;
    out_load       = 1'b0;
    done           = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          rd_cnt_nxt     = '0;
          cmp_vld_nxt    = 1'b0;
          res_status_nxt = rwst_pkg::STAT_OK;
          res_found_nxt  = 1'b0;
          res_seq_nxt    = '0;
          res_pay_nxt    = '0;
          res_cnt_nxt    = '0;
          state_nxt      = S_SCAN;
        end
      end
      S_SCAN: begin
        // Read stage: fetch the next active slot; its compare happens next cycle.
        if (rd_cnt_r < live_n) begin
          mem_ctl.rd_en = 1'b1;
          rd_cnt_nxt    = rd_cnt_r + CW'(1);
          cmp_vld_nxt   = 1'b1;
          cmp_idx_nxt   = rd_cnt_r[IW-1:0];
        end else begin
          cmp_vld_nxt   = 1'b0;
        end
        case (func_r)
          rwst_pkg::FUNC_ADD: begin
            if (cmp_vld_r && !slot_busy) begin
              // A zero sequence writes the descriptor but leaves the slot free.
              mem_ctl.wr_en       = 1'b1;
              occ_nxt[cmp_idx_r]  = (key_r != '0);
              done                = 1'b1;
            end else if (scan_end) begin
              res_status_nxt = rwst_pkg::STAT_FULL;
              done           = 1'b1;
            end
          end
          rwst_pkg::FUNC_REMOVE: begin
            if (cmp_vld_r && slot_busy && key_eq) begin
              occ_nxt[cmp_idx_r] = 1'b0;
              done               = 1'b1;
            end else if (scan_end) begin
              res_status_nxt = rwst_pkg::STAT_NOT_FOUND;
              done           = 1'b1;
            end
          end
          rwst_pkg::FUNC_LOOKUP: begin
            if (cmp_vld_r && slot_busy && key_eq) begin
              res_found_nxt = 1'b1;
              res_seq_nxt   = rd_seq;
              res_pay_nxt   = rd_payload;
              done          = 1'b1;
            end else if (scan_end) begin
              res_status_nxt = rwst_pkg::STAT_NOT_FOUND;
              done           = 1'b1;
            end
          end
          rwst_pkg::FUNC_ACK: begin
            if (cmp_vld_r && slot_busy && key_le) begin
              occ_nxt[cmp_idx_r] = 1'b0;
              res_cnt_nxt        = res_cnt_r + rwst_pkg::CNT_W'(1);
            end
            if (scan_end) begin
              done = 1'b1;
            end
          end
          rwst_pkg::FUNC_CLEAR: begin
            occ_nxt = '0;
            done    = 1'b1;
          end
          default: begin
            done = 1'b1;
          end
        endcase
        if (done) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (!out_valid_r || !out_stall) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      active_r    <= rwst_pkg::ACTIVE_RESET;
      occ_r       <= '0;
      rd_cnt_r    <= '0;
      cmp_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      occ_r     <= occ_nxt;
      rd_cnt_r  <= rd_cnt_nxt;
      cmp_vld_r <= cmp_vld_nxt;
      if (cfg_valid && cfg_ready) begin
        active_r <= cfg_active_slots;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cmp_idx_r    <= cmp_idx_nxt;
    res_status_r <= res_status_nxt;
    res_found_r  <= res_found_nxt;
    res_seq_r    <= res_seq_nxt;
    res_pay_r    <= res_pay_nxt;
    res_cnt_r    <= res_cnt_nxt;
    if (in_accept) begin
      func_r <= in_func;
      key_r  <= in_seq_key;
      pay_r  <= in_entry_payload;
    end
    if (out_load) begin
      out_status_r <= res_status_r;
      out_found_r  <= res_found_r;
      out_seq_r    <= res_seq_r;
      out_pay_r    <= res_pay_r;
      out_cnt_r    <= res_cnt_r;
      out_full_r   <= full_now;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_found         = out_found_r;
  assign out_seq           = out_seq_r;
  assign out_payload       = out_pay_r;
  assign out_removed_count = out_cnt_r;
  assign out_window_full   = out_full_r;

endmodule

// ===== bench/retransmit_window_slot_table_tb.sv =====
// Self-checking testbench for the retransmission window slot table, with directed and random items.
module retransmit_window_slot_table_tb;

  localparam int SLOTS         = 8;
  localparam int MAX_WAIT      = 18;
  localparam int SETTLE_CYCLES = SLOTS + 8;
  localparam int HOLD_CYCLES   = 300;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int PHASES        = 9;
  localparam int PHASE_ITEMS   = 140;

  // Codes the block does not define; they must leave the table alone.
  localparam logic [rwst_pkg::FUNC_W-1:0] FUNC_SPARE_5 = 3'd5;
  localparam logic [rwst_pkg::FUNC_W-1:0] FUNC_SPARE_6 = 3'd6;
  localparam logic [rwst_pkg::FUNC_W-1:0] FUNC_SPARE_7 = 3'd7;

  localparam logic [rwst_pkg::SEQ_W-1:0] SEQ_FREE = '0;
  localparam logic [rwst_pkg::SEQ_W-1:0] SEQ_MAX  = '1;
  localparam logic [rwst_pkg::PAY_W-1:0] PAY_ONES = '1;

  typedef struct {
    logic [rwst_pkg::STATUS_W-1:0] status;
    logic                          found;
    logic [rwst_pkg::SEQ_W-1:0]    seq;
    logic [rwst_pkg::PAY_W-1:0]    payload;
    logic [rwst_pkg::CNT_W-1:0]    removed;
    logic                          full;
  } op_result_t;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [rwst_pkg::CFG_W-1:0]    cfg_active_slots = '0;
  logic                          in_valid = 1'b0;
  logic                          in_stall;
  logic [rwst_pkg::FUNC_W-1:0]   in_func = rwst_pkg::FUNC_ADD;
  logic [rwst_pkg::SEQ_W-1:0]    in_seq_key = '0;
  logic [rwst_pkg::PAY_W-1:0]    in_entry_payload = '0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic [rwst_pkg::STATUS_W-1:0] out_status;
  logic                          out_found;
  logic [rwst_pkg::SEQ_W-1:0]    out_seq;
  logic [rwst_pkg::PAY_W-1:0]    out_payload;
  logic [rwst_pkg::CNT_W-1:0]    out_removed_count;
  logic                          out_window_full;

  // Shadow copy of the slot table and the active count register.
  logic [rwst_pkg::SEQ_W-1:0] shadow_seq [SLOTS];
  logic [rwst_pkg::PAY_W-1:0] shadow_pay [SLOTS];
  logic [rwst_pkg::CFG_W-1:0] shadow_active;

  op_result_t pending_results [$];
  int fail_count = 0;
  int cycle_cnt = 0;
  bit burst_mode = 1'b0;
  int rx_hold_req = 0;
  logic [rwst_pkg::SEQ_W-1:0] win_base = '0;

  retransmit_window_slot_table #(.SLOTS(SLOTS)) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_active_slots (cfg_active_slots),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_func          (in_func),
    .in_seq_key       (in_seq_key),
    .in_entry_payload (in_entry_payload),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_found        (out_found),
    .out_seq          (out_seq),
    .out_payload      (out_payload),
    .out_removed_count(out_removed_count),
    .out_window_full  (out_window_full)
  );

  always #2 clk = ~clk;

  function automatic int live_slots();
    int n;
    n = shadow_active;
    if (n < 1) n = 1;
    if (n > SLOTS) n = SLOTS;
    return n;
  endfunction

  function automatic int first_slot_with(logic [rwst_pkg::SEQ_W-1:0] seq, int n);
    for (int i = 0; i < n; i++)
      if (shadow_seq[i] == seq) return i;
    return -1;
  endfunction

  // Applies one operation to the shadow table and returns the result it should produce.
  function automatic op_result_t table_apply(logic [rwst_pkg::FUNC_W-1:0] func,
                                             logic [rwst_pkg::SEQ_W-1:0] key,
                                             logic [rwst_pkg::PAY_W-1:0] pay);
    op_result_t r;
    int n;
    int k;
    n = live_slots();
    r.status = rwst_pkg::STAT_OK;
    r.found = 1'b0;
    r.seq = '0;
    r.payload = '0;
    r.removed = '0;
    case (func)
      rwst_pkg::FUNC_ADD: begin
        k = first_slot_with(SEQ_FREE, n);
        if (k < 0) begin
          r.status = rwst_pkg::STAT_FULL;
        end else begin
          shadow_seq[k] = key;
          shadow_pay[k] = pay;
        end
      end
      rwst_pkg::FUNC_REMOVE: begin
        k = (key == SEQ_FREE) ? -1 : first_slot_with(key, n);
        if (k < 0) r.status = rwst_pkg::STAT_NOT_FOUND;
        else shadow_seq[k] = SEQ_FREE;
      end
      rwst_pkg::FUNC_ACK: begin
        for (int i = 0; i < n; i++) begin
          if (shadow_seq[i] != SEQ_FREE && shadow_seq[i] <= key) begin
            shadow_seq[i] = SEQ_FREE;
            r.removed = r.removed + 1'b1;
          end
        end
      end
      rwst_pkg::FUNC_LOOKUP: begin
        k = (key == SEQ_FREE) ? -1 : first_slot_with(key, n);
        if (k < 0) begin
          r.status = rwst_pkg::STAT_NOT_FOUND;
        end else begin
          r.found = 1'b1;
          r.seq = shadow_seq[k];
          r.payload = shadow_pay[k];
        end
      end
      rwst_pkg::FUNC_CLEAR: begin
        for (int i = 0; i < SLOTS; i++) shadow_seq[i] = SEQ_FREE;
      end
      default: ;
    endcase
    r.full = (first_slot_with(SEQ_FREE, n) < 0);
    return r;
  endfunction

  function automatic logic [rwst_pkg::PAY_W-1:0] rand_payload();
    return {$urandom, $urandom};
  endfunction

  // Keys mostly come from a sliding window of recent sequence numbers, so hits are common.
  function automatic logic [rwst_pkg::SEQ_W-1:0] pick_key(int spread);
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return win_base + $urandom_range(0, spread);
    if (r < 90) return ($urandom_range(0, 1) != 0) ? SEQ_MAX : SEQ_FREE;
    return $urandom;
  endfunction

  task automatic offer_op(input logic [rwst_pkg::FUNC_W-1:0] func,
                          input logic [rwst_pkg::SEQ_W-1:0] key,
                          input logic [rwst_pkg::PAY_W-1:0] pay);
    int gap;
    gap = burst_mode ? 0 : $urandom_range(0, MAX_WAIT);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_func <= func;
    in_seq_key <= key;
    in_entry_payload <= pay;
    do @(posedge clk); while (in_stall);
    pending_results.push_back(table_apply(func, key, pay));
  endtask

  task automatic wait_results_done();
    in_valid <= 1'b0;
    while (pending_results.size() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_active_slots(input logic [rwst_pkg::CFG_W-1:0] value);
    wait_results_done();
    cfg_valid <= 1'b1;
    cfg_active_slots <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    shadow_active = value;
  endtask

  task automatic compare_field(input string name, input logic [rwst_pkg::PAY_W-1:0] want,
                               input logic [rwst_pkg::PAY_W-1:0] got);
    if (got !== want) begin
      fail_count++;
      $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
    end
  endtask

  task automatic test_directed();
    offer_op(rwst_pkg::FUNC_LOOKUP, SEQ_FREE, rand_payload());
    offer_op(rwst_pkg::FUNC_REMOVE, SEQ_FREE, rand_payload());
    offer_op(rwst_pkg::FUNC_ACK, SEQ_FREE, rand_payload());
    offer_op(FUNC_SPARE_5, SEQ_MAX, PAY_ONES);
    offer_op(FUNC_SPARE_6, $urandom, rand_payload());
    offer_op(FUNC_SPARE_7, $urandom, rand_payload());
    // A zero sequence writes the payload but leaves the slot free.
    offer_op(rwst_pkg::FUNC_ADD, SEQ_FREE, PAY_ONES);
    offer_op(rwst_pkg::FUNC_ADD, SEQ_MAX, PAY_ONES);
    offer_op(rwst_pkg::FUNC_ADD, 32'd1, '0);
    for (int s = 2; s <= 7; s++) offer_op(rwst_pkg::FUNC_ADD, s, rand_payload());
    offer_op(rwst_pkg::FUNC_ADD, 32'd8, rand_payload());
    offer_op(rwst_pkg::FUNC_LOOKUP, SEQ_MAX, rand_payload());
    offer_op(rwst_pkg::FUNC_LOOKUP, 32'd1, rand_payload());
    offer_op(rwst_pkg::FUNC_REMOVE, 32'd1, rand_payload());
    offer_op(rwst_pkg::FUNC_REMOVE, 32'd1, rand_payload());
    offer_op(rwst_pkg::FUNC_ACK, SEQ_MAX - 1, rand_payload());
    offer_op(rwst_pkg::FUNC_ACK, SEQ_MAX, rand_payload());
    offer_op(rwst_pkg::FUNC_ADD, 32'd5, rand_payload());
    offer_op(rwst_pkg::FUNC_CLEAR, $urandom, rand_payload());
    offer_op(rwst_pkg::FUNC_LOOKUP, 32'd5, rand_payload());
  endtask

  task automatic test_active_count();
    set_active_slots(7'd1);
    offer_op(rwst_pkg::FUNC_ADD, 32'd10, rand_payload());
    offer_op(rwst_pkg::FUNC_ADD, 32'd11, rand_payload());
    offer_op(rwst_pkg::FUNC_LOOKUP, 32'd10, rand_payload());
    offer_op(rwst_pkg::FUNC_ACK, SEQ_MAX, rand_payload());
    // Zero is taken as one slot.
    set_active_slots(7'd0);
    offer_op(rwst_pkg::FUNC_ADD, 32'd12, rand_payload());
    offer_op(rwst_pkg::FUNC_ADD, 32'd13, rand_payload());
    // Above the built slot count the whole table is active.
    set_active_slots(7'd9);
    offer_op(rwst_pkg::FUNC_ADD, 32'd21, rand_payload());
    for (int s = 21; s <= 27; s++) offer_op(rwst_pkg::FUNC_ADD, s, rand_payload());
    offer_op(rwst_pkg::FUNC_REMOVE, 32'd21, rand_payload());
    offer_op(rwst_pkg::FUNC_LOOKUP, 32'd21, rand_payload());
    // Shrinking the window hides the upper slots without touching them.
    set_active_slots(7'd3);
    offer_op(rwst_pkg::FUNC_LOOKUP, 32'd24, rand_payload());
    offer_op(rwst_pkg::FUNC_ACK, SEQ_MAX, rand_payload());
    for (int s = 30; s <= 33; s++) offer_op(rwst_pkg::FUNC_ADD, s, rand_payload());
    set_active_slots(7'd64);
    offer_op(rwst_pkg::FUNC_LOOKUP, 32'd24, rand_payload());
    offer_op(rwst_pkg::FUNC_ACK, 32'd25, rand_payload());
    offer_op(rwst_pkg::FUNC_CLEAR, $urandom, rand_payload());
    offer_op(rwst_pkg::FUNC_LOOKUP, 32'd26, rand_payload());
    set_active_slots(7'd127);
    for (int s = 40; s <= 47; s++) offer_op(rwst_pkg::FUNC_ADD, s, rand_payload());
    // Clear reaches slots outside the window as well.
    set_active_slots(7'd2);
    offer_op(rwst_pkg::FUNC_CLEAR, $urandom, rand_payload());
    set_active_slots(rwst_pkg::ACTIVE_RESET);
    offer_op(rwst_pkg::FUNC_LOOKUP, 32'd47, rand_payload());
    offer_op(rwst_pkg::FUNC_ADD, 32'd50, rand_payload());
  endtask

  task automatic test_backpressure();
    wait_results_done();
    burst_mode = 1'b1;
    rx_hold_req = HOLD_CYCLES;
    win_base = $urandom;
    for (int i = 0; i < 16; i++)
      offer_op((i % 2 == 0) ? rwst_pkg::FUNC_ADD : rwst_pkg::FUNC_LOOKUP, pick_key(6),
               rand_payload());
    burst_mode = 1'b0;
  endtask

  task automatic test_sender_pause();
    for (int i = 0; i < 6; i++) offer_op(rwst_pkg::FUNC_ADD, pick_key(6), rand_payload());
    wait_results_done();
    for (int i = 0; i < 6; i++) offer_op(rwst_pkg::FUNC_REMOVE, pick_key(6), rand_payload());
  endtask

  task automatic test_random();
    logic [rwst_pkg::CFG_W-1:0] phase_active [PHASES];
    logic [rwst_pkg::FUNC_W-1:0] func;
    int roll;
    phase_active = '{rwst_pkg::ACTIVE_RESET, 7'd1, 7'd4, 7'd64, 7'd0, 7'd6, 7'd127, 7'd2,
                     7'd8};
    for (int p = 0; p < PHASES; p++) begin
      set_active_slots(phase_active[p]);
      win_base = ($urandom_range(0, 3) == 0) ? SEQ_MAX - 40 : $urandom;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (i % 50 == 0) burst_mode = ($urandom_range(0, 3) == 0);
        roll = $urandom_range(0, 99);
        if (roll < 35) func = rwst_pkg::FUNC_ADD;
        else if (roll < 55) func = rwst_pkg::FUNC_REMOVE;
        else if (roll < 70) func = rwst_pkg::FUNC_ACK;
        else if (roll < 94) func = rwst_pkg::FUNC_LOOKUP;
        else if (roll < 97) func = rwst_pkg::FUNC_CLEAR;
        else func = rwst_pkg::FUNC_W'($urandom_range(FUNC_SPARE_5, FUNC_SPARE_7));
        offer_op(func, pick_key((func == rwst_pkg::FUNC_ACK) ? 24 : 12), rand_payload());
        // The window slides forward now and then, as acknowledged traffic would.
        if ($urandom_range(0, 19) == 0) win_base = win_base + $urandom_range(1, 6);
      end
      burst_mode = 1'b0;
    end
  endtask

  // Result receiver: may raise out_stall for a random or requested hold before taking each item.
  initial begin : result_sink
    int hold;
    forever begin
      hold = burst_mode ? 0 : $urandom_range(0, MAX_WAIT);
      if (rx_hold_req > 0) begin
        hold = rx_hold_req;
        rx_hold_req = 0;
      end
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (!(rst_n && out_valid));
    end
  end

  always @(posedge clk) begin : result_check
    op_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        fail_count++;
        $display("%0t: result with nothing expected: status %h found %h seq %h", $time,
                 out_status, out_found, out_seq);
      end else begin
        want = pending_results.pop_front();
        compare_field("status", want.status, out_status);
        compare_field("found", want.found, out_found);
        compare_field("seq", want.seq, out_seq);
        compare_field("payload", want.payload, out_payload);
        compare_field("removed_count", want.removed, out_removed_count);
        compare_field("window_full", want.full, out_window_full);
      end
    end
  end

  initial begin : watchdog
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    for (int i = 0; i < SLOTS; i++) begin
      shadow_seq[i] = SEQ_FREE;
      shadow_pay[i] = '0;
    end
    shadow_active = rwst_pkg::ACTIVE_RESET;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_active_count();
    test_backpressure();
    test_sender_pause();
    test_random();
    wait_results_done();
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/rwst_pkg.sv
rtl/rwst_slot_store.sv
rtl/retransmit_window_slot_table.sv
bench/retransmit_window_slot_table_tb.sv
